// ----- hdl/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg
// Types, constants and the control store of the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // default operand width
  localparam int unsigned VALUE_WIDTH = 32;

  // step counter width, which also sets the length of the control store
  localparam int unsigned UPC_W = 4;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_SET,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_D_INC,
    OP_PASS,
    OP_FAIL,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_LE1,
    C_LE3,
    C_EVEN,
    C_LOOP,
    C_D_GT_ROOT,
    C_REM_ZERO,
    C_OUT_WAIT
  } cond_e;

  // program steps
  localparam logic [UPC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] ST_LE1   = 4'd1;
  localparam logic [UPC_W-1:0] ST_LE3   = 4'd2;
  localparam logic [UPC_W-1:0] ST_EVEN  = 4'd3;
  localparam logic [UPC_W-1:0] ST_SQI   = 4'd4;
  localparam logic [UPC_W-1:0] ST_SQS   = 4'd5;
  localparam logic [UPC_W-1:0] ST_DSET  = 4'd6;
  localparam logic [UPC_W-1:0] ST_DCMP  = 4'd7;
  localparam logic [UPC_W-1:0] ST_DVI   = 4'd8;
  localparam logic [UPC_W-1:0] ST_DVS   = 4'd9;
  localparam logic [UPC_W-1:0] ST_ZERO  = 4'd10;
  localparam logic [UPC_W-1:0] ST_DINC  = 4'd11;
  localparam logic [UPC_W-1:0] ST_PASS  = 4'd12;
  localparam logic [UPC_W-1:0] ST_FAIL  = 4'd13;
  localparam logic [UPC_W-1:0] ST_OUT   = 4'd14;
  localparam logic [UPC_W-1:0] ST_WRAP  = 4'd15;

  // one control word: operation, jump condition, jump target
  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctl_t;

  // control store: taken jump goes to target, otherwise to the next step
  function automatic ctl_t rom_word(input logic [UPC_W-1:0] step);
    ctl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
    case (step)
      ST_IDLE: w = '{op: OP_LOAD,      cond: C_NO_IN,     target: ST_IDLE};
      ST_LE1:  w = '{op: OP_NOP,       cond: C_LE1,       target: ST_FAIL};
      ST_LE3:  w = '{op: OP_NOP,       cond: C_LE3,       target: ST_PASS};
      ST_EVEN: w = '{op: OP_NOP,       cond: C_EVEN,      target: ST_FAIL};
      ST_SQI:  w = '{op: OP_SQRT_INIT, cond: C_NEVER,     target: ST_IDLE};
      ST_SQS:  w = '{op: OP_SQRT_STEP, cond: C_LOOP,      target: ST_SQS};
      ST_DSET: w = '{op: OP_DIV_SET,   cond: C_NEVER,     target: ST_IDLE};
      ST_DCMP: w = '{op: OP_NOP,       cond: C_D_GT_ROOT, target: ST_PASS};
      ST_DVI:  w = '{op: OP_DIV_INIT,  cond: C_NEVER,     target: ST_IDLE};
      ST_DVS:  w = '{op: OP_DIV_STEP,  cond: C_LOOP,      target: ST_DVS};
      ST_ZERO: w = '{op: OP_NOP,       cond: C_REM_ZERO,  target: ST_FAIL};
      ST_DINC: w = '{op: OP_D_INC,     cond: C_ALWAYS,    target: ST_DCMP};
      ST_PASS: w = '{op: OP_PASS,      cond: C_ALWAYS,    target: ST_OUT};
      ST_FAIL: w = '{op: OP_FAIL,      cond: C_NEVER,     target: ST_IDLE};
      ST_OUT:  w = '{op: OP_EMIT,      cond: C_OUT_WAIT,  target: ST_OUT};
      ST_WRAP: w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ST_IDLE};
      default: w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/trial_division_prime_test_top.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Tests one signed integer per beat for primality by trial division.
// ----------------------------------------------------------------------------
// One candidate is taken at a time and one result beat (bit 0 = is_prime) is
// given back for it. Negative values, 0 and 1 give 0; 2 and 3 give 1; even
// values give 0. For odd n >= 5 the block runs an integer square root, one
// base-4 digit per cycle, then tries 3, 5, 7 .. up to floor(sqrt(n)) with a
// bit-serial remainder unit; composites stop at their smallest odd factor. A
// new candidate is taken only after the previous result beat has been taken.
// Control is a 16-step program in a constant control store.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // candidate [VALUE_WIDTH-1:0], zero filled to whole bytes
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // is_prime [0], zeros above
  output logic [7:0]                      m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  localparam int unsigned W        = VALUE_WIDTH;
  localparam int unsigned CW       = $clog2(W + 1);
  localparam int unsigned SQ_STEPS = (W - 1) / 2 + 1;
  localparam int unsigned TOP_POS  = 2 * ((W - 1) / 2);

  // sequencer state
  logic [tdpt_pkg::UPC_W-1:0] upc_q, upc_d;
  tdpt_pkg::ctl_t             ctl;
  logic                       take;

  // datapath registers
  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  root_q, root_d;
  logic [W-1:0]  bit_q, bit_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  d_q, d_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          prime_q, prime_d;

  // square root and remainder arithmetic
  logic [W:0] sq_sum;
  logic       sq_ge;
  logic [W:0] dv_sh;
  logic       dv_ge;

  assign ctl = tdpt_pkg::rom_word(upc_q);

  // handshake straight from the current control word
  assign s_axis_tready_o = (ctl.op == tdpt_pkg::OP_LOAD);
  assign m_axis_tvalid_o = (ctl.op == tdpt_pkg::OP_EMIT);
  assign m_axis_tdata_o  = {7'b0, prime_q};

  // jump condition
  always_comb begin
    case (ctl.cond)
      tdpt_pkg::C_NEVER:     take = 1'b0;
      tdpt_pkg::C_ALWAYS:    take = 1'b1;
      tdpt_pkg::C_NO_IN:     take = !s_axis_tvalid_i;
      tdpt_pkg::C_LE1:       take = n_q[W-1] || (n_q < W'(2));
      tdpt_pkg::C_LE3:       take = (n_q < W'(4));
      tdpt_pkg::C_EVEN:      take = !n_q[0];
      tdpt_pkg::C_LOOP:      take = (cnt_q != CW'(1));
      tdpt_pkg::C_D_GT_ROOT: take = (d_q > root_q);
      tdpt_pkg::C_REM_ZERO:  take = (rem_q == '0);
      tdpt_pkg::C_OUT_WAIT:  take = !m_axis_tready_i;
      default:               take = 1'b1;
    endcase
    upc_d = take ? ctl.target : upc_q + tdpt_pkg::UPC_W'(1);
  end

  // square root digit and remainder step
  assign sq_sum = {1'b0, root_q} + {1'b0, bit_q};
  assign sq_ge  = ({1'b0, rem_q} >= sq_sum);
  assign dv_sh  = {rem_q, bit_q[W-1]};
  assign dv_ge  = (dv_sh >= {1'b0, d_q});

  // datapath operations
  always_comb begin
    n_d     = n_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    d_d     = d_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;
    case (ctl.op)
      tdpt_pkg::OP_LOAD: begin
        n_d = s_axis_tdata_i[W-1:0];
      end
      tdpt_pkg::OP_SQRT_INIT: begin
        rem_d  = n_q;
        root_d = '0;
        bit_d  = W'(1) << TOP_POS;
        cnt_d  = CW'(SQ_STEPS);
      end
      tdpt_pkg::OP_SQRT_STEP: begin
        if (sq_ge) begin
          rem_d  = rem_q - sq_sum[W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - CW'(1);
      end
      tdpt_pkg::OP_DIV_SET: begin
        d_d = W'(3);
      end
      tdpt_pkg::OP_DIV_INIT: begin
        rem_d = '0;
        bit_d = n_q;
        cnt_d = CW'(W);
      end
      tdpt_pkg::OP_DIV_STEP: begin
        rem_d = dv_ge ? W'(dv_sh - {1'b0, d_q}) : dv_sh[W-1:0];
        bit_d = bit_q << 1;
        cnt_d = cnt_q - CW'(1);
      end
      tdpt_pkg::OP_D_INC: begin
        d_d = d_q + W'(2);
      end
      tdpt_pkg::OP_PASS: begin
        prime_d = 1'b1;
      end
      tdpt_pkg::OP_FAIL: begin
        prime_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= tdpt_pkg::ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    rem_q   <= rem_d;
    d_q     <= d_d;
    cnt_q   <= cnt_d;
    prime_q <= prime_d;
  end

  // never ready for input while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result valid");

  // trial divisors are odd and at least 3
  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == tdpt_pkg::OP_DIV_STEP) |-> (d_q[0] && d_q >= W'(3)))
    else $error("bad trial divisor");

  // square root digit is a single bit while stepping
  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == tdpt_pkg::OP_SQRT_STEP) |-> $onehot(bit_q))
    else $error("square root digit lost");

  // an accepted candidate leaves the idle step
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (upc_q == tdpt_pkg::ST_LE1))
    else $error("accepted beat not started");

endmodule
